// File: hw/rtl/ultrasonic_range_median_macros.svh
// Assertion macros for the ultrasonic ranging checker.
`ifndef ULTRASONIC_RANGE_MEDIAN_MACROS_SVH
`define ULTRASONIC_RANGE_MEDIAN_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define URM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define URM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/urm_pkg.sv
// Shared types and constants for the ultrasonic ranging block.
package urm_pkg;

    localparam int BURST_SAMPLES = 5;
    localparam int COUNT_BITS    = 16;
    localparam int US_PER_CM     = 58;

    localparam int TRIG_W    = 10;
    localparam int GAP_W     = 18;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 1;
    localparam int CM_W      = 11;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAP    = CFG_IDX_W'(1);

    localparam logic [TRIG_W-1:0]     TRIG_RESET = TRIG_W'(10);
    localparam logic [GAP_W-1:0]      GAP_RESET  = GAP_W'(200000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [CM_W-1:0]       CM_MAX     = CM_W'(2047);

    localparam int TAKEN_W = $clog2(BURST_SAMPLES + 1);
    localparam int RANK_W  = $clog2(BURST_SAMPLES);
    localparam logic [RANK_W-1:0]  MEDIAN_RANK = RANK_W'(BURST_SAMPLES / 2);
    localparam logic [TAKEN_W-1:0] BURST_LAST  = TAKEN_W'(BURST_SAMPLES);

    // x / US_PER_CM == (x * RECIP) >> DIV_SHIFT for every x below 2^COUNT_BITS
    localparam int DIV_SHIFT = COUNT_BITS + 8;
    localparam int RECIP_W   = COUNT_BITS + 9;
    localparam int PROD_W    = COUNT_BITS + RECIP_W;
    localparam int Q_W       = PROD_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + US_PER_CM - 1) / US_PER_CM);

    typedef logic [COUNT_BITS-1:0] width_t;
    typedef width_t [BURST_SAMPLES-1:0] width_set_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_COUNT,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
    } flags_t;

endpackage

// File: hw/rtl/ultrasonic_range_median.sv
// Top level of the ultrasonic ranging block with median-of-burst result.
//
// Usage:
//  - Slave stream: one item per microsecond tick of the pin sampler.
//    s_tdata[0] start_req, s_tdata[1] echo_level. A start while idle opens a
//    burst of five measurements: trigger pulse, wait for echo, count echo
//    width (saturating), then the programmed gap.
//  - Master stream: exactly one item per input item, in order.
//    m_tdata carries trigger_out, busy_res and median_cm; m_tuser carries
//    done_res, high on the tick where the last echo of the burst falls.
//    median_cm is the median width / 58 on that tick and zero otherwise.
//  - Config port: cfg_we writes cfg_wdata to register cfg_addr
//    (0 trigger width, 1 gap). Write only while no items are in flight.
//  - Pipeline: five register stages; an accepted item passes through each in
//    order before it shows on m_tvalid. Throughput one item per cycle while
//    m_tready is high, set by the sequencer update in stage two.
//  - Stall: each stage holds while the one after it is full and stuck, so
//    bubbles are squeezed out and s_tready drops only once all stages fill.
//  - Reset: sequencer idle, registers at trigger width 10 and gap 200000,
//    pipeline empty.
module ultrasonic_range_median (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [urm_pkg::IN_W-1:0]      s_tdata,   // [0] start_req, [1] echo_level
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [urm_pkg::OUT_W-1:0]     m_tdata,   // [0] trigger_out, [1] busy_res,
                                                     // [12:2] median_cm
    output logic [0:0]                    m_tuser,   // [0] done_res
    input  logic                          cfg_we,
    input  logic [urm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [urm_pkg::CFG_W-1:0]     cfg_wdata
);

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: input register
    logic                            start_reg;
    logic                            echo_reg;
    // stage 2: sequencer flags
    urm_pkg::flags_t                 s2_flags_reg;
    urm_pkg::flags_t                 ctrl_flags;
    urm_pkg::width_set_t             widths;
    // stage 3: median
    urm_pkg::flags_t                 s3_flags_reg;
    urm_pkg::width_t                 median_reg, median_next;
    // stage 4: reciprocal product
    urm_pkg::flags_t                 s4_flags_reg;
    logic [urm_pkg::PROD_W-1:0]      prod_reg, prod_next;
    // stage 5: result
    urm_pkg::flags_t                 s5_flags_reg;
    logic [urm_pkg::CM_W-1:0]        cm_reg, cm_next;
    logic [urm_pkg::Q_W-1:0]         quot;

    // a stage takes a new item when empty or when its item moves on
    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // sequencer advances once per item, as the item leaves stage 1
    urm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .step       (v1_reg && rdy2),
        .start_req  (start_reg),
        .echo_level (echo_reg),
        .flags      (ctrl_flags),
        .widths     (widths)
    );

    // store is stable while the item that finished the burst sits in stage 2
    urm_median u_median (
        .widths (widths),
        .median (median_next)
    );

    assign prod_next = urm_pkg::PROD_W'(median_reg) * urm_pkg::PROD_W'(urm_pkg::RECIP);
    assign quot      = prod_reg[urm_pkg::PROD_W-1:urm_pkg::DIV_SHIFT];

    always_comb
    begin
        cm_next = '0;
        if (s4_flags_reg.done)
        begin
            if (quot > urm_pkg::Q_W'(urm_pkg::CM_MAX))
            begin
                cm_next = urm_pkg::CM_MAX;
            end
            else
            begin
                cm_next = quot[urm_pkg::CM_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            start_reg <= s_tdata[0];
            echo_reg  <= s_tdata[1];
        end
        if (rdy2)
        begin
            s2_flags_reg <= ctrl_flags;
        end
        if (rdy3)
        begin
            s3_flags_reg <= s2_flags_reg;
            median_reg   <= median_next;
        end
        if (rdy4)
        begin
            s4_flags_reg <= s3_flags_reg;
            prod_reg     <= prod_next;
        end
        if (rdy5)
        begin
            s5_flags_reg <= s4_flags_reg;
            cm_reg       <= cm_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {(urm_pkg::OUT_W - urm_pkg::CM_W - 2)'(0), cm_reg,
                       s5_flags_reg.busy, s5_flags_reg.trig};
    assign m_tuser  = s5_flags_reg.done;

endmodule

// File: hw/rtl/urm_ctrl.sv
// Measurement sequencer: phase, timers, echo counter and width store.
module urm_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [urm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [urm_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             step,
    input  logic                             start_req,
    input  logic                             echo_level,
    output urm_pkg::flags_t                  flags,
    output urm_pkg::width_set_t              widths
);

    urm_pkg::phase_t                   phase_reg, phase_next, cur_phase;
    logic [urm_pkg::GAP_W-1:0]         timer_reg, timer_next, cur_timer, timer_inc;
    logic [urm_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic [urm_pkg::TAKEN_W-1:0]       taken_reg, taken_next, cur_taken, taken_inc;
    logic [urm_pkg::TRIG_W-1:0]        trig_width_reg;
    logic [urm_pkg::GAP_W-1:0]         gap_reg;
    urm_pkg::width_set_t               store_reg;
    logic                              start_now;
    logic                              last_sample;
    logic                              store_we;

    // a start seen while idle turns this tick into the first trigger tick
    assign start_now   = (phase_reg == urm_pkg::PH_IDLE) && start_req;
    assign cur_phase   = start_now ? urm_pkg::PH_TRIG : phase_reg;
    assign cur_timer   = start_now ? '0 : timer_reg;
    assign cur_taken   = start_now ? '0 : taken_reg;
    assign timer_inc   = cur_timer + urm_pkg::GAP_W'(1);
    assign taken_inc   = cur_taken + urm_pkg::TAKEN_W'(1);
    assign last_sample = taken_inc >= urm_pkg::BURST_LAST;

    // next state
    always_comb
    begin
        phase_next = cur_phase;
        timer_next = cur_timer;
        count_next = count_reg;
        taken_next = cur_taken;
        store_we   = 1'b0;
        case (cur_phase)
            urm_pkg::PH_IDLE:
            begin
            end
            urm_pkg::PH_TRIG:
            begin
                timer_next = timer_inc;
                if (timer_inc >= urm_pkg::GAP_W'(trig_width_reg))
                begin
                    phase_next = urm_pkg::PH_WAIT;
                end
            end
            urm_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    count_next = urm_pkg::COUNT_BITS'(1);
                    phase_next = urm_pkg::PH_COUNT;
                end
            end
            urm_pkg::PH_COUNT:
            begin
                if (echo_level)
                begin
                    if (count_reg < urm_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + urm_pkg::COUNT_BITS'(1);
                    end
                end
                else
                begin
                    store_we   = cur_taken < urm_pkg::BURST_LAST;
                    taken_next = taken_inc;
                    timer_next = '0;
                    if (gap_reg != '0)
                    begin
                        phase_next = urm_pkg::PH_GAP;
                    end
                    else if (last_sample)
                    begin
                        phase_next = urm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = urm_pkg::PH_TRIG;
                    end
                end
            end
            urm_pkg::PH_GAP:
            begin
                timer_next = timer_inc;
                if (timer_inc >= gap_reg)
                begin
                    timer_next = '0;
                    if (cur_taken >= urm_pkg::BURST_LAST)
                    begin
                        phase_next = urm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = urm_pkg::PH_TRIG;
                    end
                end
            end
            default:
            begin
                phase_next = urm_pkg::PH_IDLE;
                timer_next = '0;
            end
        endcase
    end

    // per-tick flags
    always_comb
    begin
        flags.trig = cur_phase == urm_pkg::PH_TRIG;
        flags.busy = !((phase_reg == urm_pkg::PH_IDLE) && !start_req);
        flags.done = (cur_phase == urm_pkg::PH_COUNT) && !echo_level && last_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urm_pkg::PH_IDLE;
            timer_reg <= '0;
            count_reg <= '0;
            taken_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width_reg <= urm_pkg::TRIG_RESET;
            gap_reg        <= urm_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                urm_pkg::REG_TRIGGER_WIDTH: trig_width_reg <= cfg_wdata[urm_pkg::TRIG_W-1:0];
                urm_pkg::REG_SAMPLE_GAP:    gap_reg        <= cfg_wdata[urm_pkg::GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // width store: only read after a full burst has been written
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < urm_pkg::BURST_SAMPLES; i++)
        begin
            if (step && store_we && (cur_taken == urm_pkg::TAKEN_W'(i)))
            begin
                store_reg[i] <= count_reg;
            end
        end
    end

    assign widths = store_reg;

endmodule

// File: hw/rtl/urm_median.sv
// Median select over the stored widths by stable rank.
module urm_median (
    input  urm_pkg::width_set_t widths,
    output urm_pkg::width_t     median
);

    // stable rank: smaller values, plus equal values at lower index
    always_comb
    begin
        logic [urm_pkg::RANK_W-1:0] rank;
        median = '0;
        for (int i = 0; i < urm_pkg::BURST_SAMPLES; i++)
        begin
            rank = '0;
            for (int j = 0; j < urm_pkg::BURST_SAMPLES; j++)
            begin
                if ((widths[j] < widths[i]) || ((j < i) && (widths[j] == widths[i])))
                begin
                    rank = rank + urm_pkg::RANK_W'(1);
                end
            end
            if (rank == urm_pkg::MEDIAN_RANK)
            begin
                median = widths[i];
            end
        end
    end

endmodule

// File: hw/rtl/urm_checker.sv
// Port-level checks for the ultrasonic ranging block, bound to its top level.
`include "ultrasonic_range_median_macros.svh"

module urm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [urm_pkg::OUT_W-1:0]     m_tdata,
    input logic [0:0]                    m_tuser
);

    // a finished burst is still a busy tick
    `URM_ASSERT_NOW(a_done_busy, m_tvalid && m_tuser[0], m_tdata[1], "done without busy")

    // distance only on the done tick
    `URM_ASSERT_NOW(a_cm_zero, m_tvalid && !m_tuser[0], m_tdata[12:2] == 11'd0, "median_cm not zero")

    // trigger only inside a burst
    `URM_ASSERT_NOW(a_trig_busy, m_tvalid && m_tdata[0], m_tdata[1], "trigger while idle")

    // a stalled result holds
    `URM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind ultrasonic_range_median urm_checker u_urm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
